// ----- design/sort_then_wave_arrange_assert.svh -----
// Assertion helpers for the sort-then-wave block.
`ifndef SORT_THEN_WAVE_ARRANGE_ASSERT_SVH
`define SORT_THEN_WAVE_ARRANGE_ASSERT_SVH

// Same-cycle implication.
`define STWA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stwa check failed");

// Next-cycle implication.
`define STWA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stwa check failed");

`endif

// ----- design/stwa_pkg.sv -----
package stwa_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int VALUE_W       = 32;

    typedef enum logic [2:0] {
        S_LOAD,
        S_CHECK,
        S_SETUP,
        S_MERGE,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic setup;
        logic merge;
        logic emit_init;
        logic emit_rd;
        logic emit_ld;
        logic emit_out;
    } t_cmd;

    typedef struct packed {
        logic sorted;
        logic run_end;
        logic out_taken;
    } t_stat;

endpackage

// ----- design/stwa_ram.sv -----
module stwa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ----- design/stwa_ctrl.sv -----
module stwa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_last,
    input  stwa_pkg::t_stat i_stat,
    output logic           o_ready,
    output stwa_pkg::t_cmd o_cmd
);

    import stwa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (i_valid && i_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_stat.sorted ? S_EMIT_RD : S_SETUP;
            end
            S_SETUP: begin
                n_state = S_MERGE;
            end
            S_MERGE: begin
                if (i_stat.run_end) begin
                    n_state = S_CHECK;
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                n_state = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                if (i_stat.out_taken) begin
                    n_state = i_stat.run_end ? S_LOAD : S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            S_CHECK: begin
                o_cmd.emit_init = i_stat.sorted;
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
            end
            S_MERGE: begin
                o_cmd.merge = 1'b1;
            end
            S_EMIT_RD: begin
                o_cmd.emit_rd = 1'b1;
            end
            S_EMIT_LD: begin
                o_cmd.emit_ld = 1'b1;
            end
            S_EMIT_OUT: begin
                o_cmd.emit_out = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ----- design/stwa_dpath.sv -----
module stwa_dpath #(
    parameter int MAX_ITEMS = stwa_pkg::MAX_ITEMS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  stwa_pkg::t_cmd                      i_cmd,
    input  logic signed [stwa_pkg::VALUE_W-1:0] i_value,
    input  logic                                i_ready,
    output stwa_pkg::t_stat                     o_stat,
    output logic                                o_valid,
    output logic signed [stwa_pkg::VALUE_W-1:0] o_value_res,
    output logic                                o_last_res,
    output logic                                o_dropped
);

    import stwa_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int WW = $clog2(MAX_ITEMS) + 1;
    localparam int SW = WW + 2;

    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic [WW-1:0] r_w;
    logic          r_src;
    logic [CW-1:0] r_pa, r_ea, r_pb, r_eb, r_k;
    logic [CW-1:0] n_pa, n_ea, n_pb, n_eb;
    logic          r_o_valid;
    logic [VALUE_W-1:0] r_o_value;
    logic          r_o_last;

    logic [VALUE_W-1:0] b0_a, b0_b, b1_a, b1_b, rd_a, rd_b, mrg_data;
    logic          take_a;
    logic [CW-1:0] wave_k;
    logic [AW-1:0] raddr_a, raddr_b;
    logic          b0_we, b1_we;
    logic [AW-1:0] b0_waddr;
    logic [VALUE_W-1:0] b0_wdata;
    logic          count_full;
    logic          pass_end;

    function automatic logic [CW-1:0] clip(input logic [SW-1:0] x, input logic [CW-1:0] lim);
        logic [CW-1:0] res;
        if (x < SW'(lim)) begin
            res = x[CW-1:0];
        end else begin
            res = lim;
        end
        return res;
    endfunction

    assign rd_a     = r_src ? b1_a : b0_a;
    assign rd_b     = r_src ? b1_b : b0_b;
    assign take_a   = (r_pa < r_ea) &&
                      ((r_pb >= r_eb) || ($signed(rd_a) <= $signed(rd_b)));
    assign mrg_data = take_a ? rd_a : rd_b;

    assign o_stat.sorted    = SW'(r_w) >= SW'(r_count);
    assign o_stat.run_end   = (SW'(r_k) + SW'(1)) == SW'(r_count);
    assign o_stat.out_taken = r_o_valid && i_ready;

    assign count_full = SW'(r_count) >= SW'(MAX_ITEMS);
    assign pass_end   = i_cmd.merge && o_stat.run_end;

    always_comb begin
        n_pa = r_pa;
        n_ea = r_ea;
        n_pb = r_pb;
        n_eb = r_eb;
        if (i_cmd.setup) begin
            n_pa = '0;
            n_ea = clip(SW'(r_w), r_count);
            n_pb = n_ea;
            n_eb = clip(SW'(r_w) << 1, r_count);
        end else if (i_cmd.merge) begin
            if ((SW'(r_k) + SW'(1)) == SW'(r_eb)) begin
                n_pa = r_eb;
                n_ea = clip(SW'(r_eb) + SW'(r_w), r_count);
                n_pb = n_ea;
                n_eb = clip(SW'(r_eb) + (SW'(r_w) << 1), r_count);
            end else if (take_a) begin
                n_pa = r_pa + CW'(1);
            end else begin
                n_pb = r_pb + CW'(1);
            end
        end
    end

    always_comb begin
        if (!r_k[0]) begin
            wave_k = (r_k == '0) ? r_k : r_k - CW'(1);
        end else if ((SW'(r_k) + SW'(1)) < SW'(r_count)) begin
            wave_k = r_k + CW'(1);
        end else begin
            wave_k = r_k;
        end
    end

    assign raddr_a = i_cmd.emit_rd ? wave_k[AW-1:0] : n_pa[AW-1:0];
    assign raddr_b = n_pb[AW-1:0];

    assign b0_we    = (i_cmd.load && !count_full) || (i_cmd.merge && r_src);
    assign b0_waddr = i_cmd.load ? r_count[AW-1:0] : r_k[AW-1:0];
    assign b0_wdata = i_cmd.load ? i_value : mrg_data;
    assign b1_we    = i_cmd.merge && !r_src;

    stwa_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ITEMS)) u_bank0 (
        .i_clk     (i_clk),
        .i_we      (b0_we),
        .i_waddr   (b0_waddr),
        .i_wdata   (b0_wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (b0_a),
        .o_rdata_b (b0_b)
    );

    stwa_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ITEMS)) u_bank1 (
        .i_clk     (i_clk),
        .i_we      (b1_we),
        .i_waddr   (r_k[AW-1:0]),
        .i_wdata   (mrg_data),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (b1_a),
        .o_rdata_b (b1_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (count_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (i_cmd.emit_ld) begin
                r_o_valid <= 1'b1;
            end
            if (i_cmd.emit_out && o_stat.out_taken) begin
                r_o_valid <= 1'b0;
                if (o_stat.run_end) begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pa <= n_pa;
        r_ea <= n_ea;
        r_pb <= n_pb;
        r_eb <= n_eb;
        if (i_cmd.load) begin
            r_w   <= WW'(1);
            r_src <= 1'b0;
        end
        if (pass_end) begin
            r_w   <= r_w << 1;
            r_src <= !r_src;
        end
        if (i_cmd.setup || i_cmd.emit_init) begin
            r_k <= '0;
        end else if (i_cmd.merge && !o_stat.run_end) begin
            r_k <= r_k + CW'(1);
        end else if (i_cmd.emit_out && o_stat.out_taken) begin
            r_k <= r_k + CW'(1);
        end
        if (i_cmd.emit_ld) begin
            r_o_value <= rd_a;
            r_o_last  <= o_stat.run_end;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_value_res = r_o_value;
    assign o_last_res  = r_o_last;
    assign o_dropped   = r_ovf;

endmodule

// ----- design/sort_then_wave_arrange.sv -----
// A set of n beats is loaded, then sorted in ceil(log2 n) merge passes (setup, one element
// per cycle, pass check). Emit reads each result beat, loads it into the output register
// and holds it there until the output takes it; the merge passes work on the two
// ping-pong element memories. One set is handled at a time.
// Reset (i_rst_n low, synchronous) clears the state, count, overflow flag and output valid;
// element memories are not cleared.
`include "sort_then_wave_arrange_assert.svh"
module sort_then_wave_arrange #(
    parameter int MAX_ITEMS = stwa_pkg::MAX_ITEMS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [stwa_pkg::VALUE_W-1:0] i_value,
    input  logic                                i_last,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [stwa_pkg::VALUE_W-1:0] o_value_res,
    output logic                                o_last_res,
    output logic                                o_dropped
);

    import stwa_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    stwa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_last  (i_last),
        .i_stat  (stat),
        .o_ready (o_ready),
        .o_cmd   (cmd)
    );

    stwa_dpath #(.MAX_ITEMS(MAX_ITEMS)) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_value     (i_value),
        .i_ready     (i_ready),
        .o_stat      (stat),
        .o_valid     (o_valid),
        .o_value_res (o_value_res),
        .o_last_res  (o_last_res),
        .o_dropped   (o_dropped)
    );

    `STWA_ASSERT_NOW(a_no_load_while_emit, i_clk, i_rst_n, o_valid, !o_ready)
    `STWA_ASSERT_NEXT(a_load_after_final, i_clk, i_rst_n, o_valid && i_ready && o_last_res, o_ready)
    `STWA_ASSERT_NEXT(a_emit_continues, i_clk, i_rst_n, o_valid && i_ready && !o_last_res, !o_ready)

endmodule
